// ----- sv/lsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants of the line segment clipper
// no dependencies
package lsc_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int CFG_INDEX_W     = 3;
    localparam int MAX_CLIPS       = 4;
    localparam int STEP_W          = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LEFT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_BOTTOM = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_RIGHT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_TOP    = 3'd3;

    localparam int WINDOW_LEFT_RST   = 0;
    localparam int WINDOW_BOTTOM_RST = 0;
    localparam int WINDOW_RIGHT_RST  = 639;
    localparam int WINDOW_TOP_RST    = 479;

    localparam int CODE_LEFT   = 0;
    localparam int CODE_RIGHT  = 1;
    localparam int CODE_BOTTOM = 2;
    localparam int CODE_TOP    = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic div_step;
        logic update;
        logic out_load;
        logic out_acc;
    } t_cmd;

    typedef struct packed {
        logic trivial_acc;
        logic trivial_rej;
        logic div_last;
    } t_status;

endpackage
`default_nettype wire

// ----- sv/lsc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// window registers, endpoint registers, multiplier and serial divider
// depends on lsc_pkg
module lsc_datapath #(
    parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  lsc_pkg::t_cmd                        i_cmd,
    output lsc_pkg::t_status                     o_status,
    input  wire                                  i_cfg_we,
    input  wire [lsc_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire signed [COORD_WIDTH-1:0]         i_cfg_data,
    input  wire signed [COORD_WIDTH-1:0]         i_start_x,
    input  wire signed [COORD_WIDTH-1:0]         i_start_y,
    input  wire signed [COORD_WIDTH-1:0]         i_end_x,
    input  wire signed [COORD_WIDTH-1:0]         i_end_y,
    output logic                                 o_accepted,
    output logic signed [COORD_WIDTH-1:0]        o_clipped_start_x,
    output logic signed [COORD_WIDTH-1:0]        o_clipped_start_y,
    output logic signed [COORD_WIDTH-1:0]        o_clipped_end_x,
    output logic signed [COORD_WIDTH-1:0]        o_clipped_end_y
);
    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int CW = $clog2(PW);
    localparam int SW = W + 3;

    localparam logic [W-1:0]  RST_LEFT   = W'(lsc_pkg::WINDOW_LEFT_RST);
    localparam logic [W-1:0]  RST_BOTTOM = W'(lsc_pkg::WINDOW_BOTTOM_RST);
    localparam logic [W-1:0]  RST_RIGHT  = W'(lsc_pkg::WINDOW_RIGHT_RST);
    localparam logic [W-1:0]  RST_TOP    = W'(lsc_pkg::WINDOW_TOP_RST);
    localparam logic [DW-1:0] Q_LIMIT    = {1'b1, {W{1'b0}}};
    localparam logic signed [SW-1:0] SAT_HI = SW'((2 ** (W - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic signed [W-1:0] r_wl, r_wb, r_wr, r_wt;
    logic signed [W-1:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [W-1:0] n_x1, n_y1, n_x2, n_y2;

    logic [DW-1:0]       r_ma, r_mb, r_md;
    logic                r_neg, r_dzero, r_vert, r_sel1;
    logic signed [W-1:0] r_base, r_edge;
    logic [PW-1:0]       r_prod, r_prod_sh;
    logic                r_pnz;
    logic [DW:0]         r_rem;
    logic [DW-1:0]       r_quo;
    logic                r_big;
    logic [CW-1:0]       r_cnt;

    function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
                                           input logic signed [W-1:0] y,
                                           input logic signed [W-1:0] wl,
                                           input logic signed [W-1:0] wb,
                                           input logic signed [W-1:0] wr,
                                           input logic signed [W-1:0] wt);
        logic [3:0] c;
        c = '0;
        if (x < wl) begin
            c[lsc_pkg::CODE_LEFT] = 1'b1;
        end else if (x > wr) begin
            c[lsc_pkg::CODE_RIGHT] = 1'b1;
        end
        if (y < wb) begin
            c[lsc_pkg::CODE_BOTTOM] = 1'b1;
        end else if (y > wt) begin
            c[lsc_pkg::CODE_TOP] = 1'b1;
        end
        return c;
    endfunction

    logic [3:0]           c1, c2, co;
    logic                 s_vert;
    logic signed [W-1:0]  s_edge, s_base;
    logic signed [DW-1:0] s_a, s_b, s_d;

    always_comb begin
        c1 = outcode(r_x1, r_y1, r_wl, r_wb, r_wr, r_wt);
        c2 = outcode(r_x2, r_y2, r_wl, r_wb, r_wr, r_wt);
        co = (c1 != 4'd0) ? c1 : c2;
        if (co[lsc_pkg::CODE_TOP]) begin
            s_vert = 1'b1;
            s_edge = r_wt;
        end else if (co[lsc_pkg::CODE_BOTTOM]) begin
            s_vert = 1'b1;
            s_edge = r_wb;
        end else if (co[lsc_pkg::CODE_RIGHT]) begin
            s_vert = 1'b0;
            s_edge = r_wr;
        end else begin
            s_vert = 1'b0;
            s_edge = r_wl;
        end
        if (s_vert) begin
            s_a    = {r_x2[W-1], r_x2} - {r_x1[W-1], r_x1};
            s_b    = {s_edge[W-1], s_edge} - {r_y1[W-1], r_y1};
            s_d    = {r_y2[W-1], r_y2} - {r_y1[W-1], r_y1};
            s_base = r_x1;
        end else begin
            s_a    = {r_y2[W-1], r_y2} - {r_y1[W-1], r_y1};
            s_b    = {s_edge[W-1], s_edge} - {r_x1[W-1], r_x1};
            s_d    = {r_x2[W-1], r_x2} - {r_x1[W-1], r_x1};
            s_base = r_y1;
        end
    end

    assign o_status.trivial_acc = ((c1 | c2) == 4'd0);
    assign o_status.trivial_rej = ((c1 & c2) != 4'd0);
    assign o_status.div_last    = (r_cnt == '0);

    // one divider step: shift in the next product bit
    logic [DW:0]   d_rem_sh;
    logic          d_ge;
    always_comb begin
        d_rem_sh = {r_rem[DW-1:0], r_prod_sh[PW-1]};
        d_ge     = (d_rem_sh >= {1'b0, r_md});
    end

    // final quotient and new coordinate
    logic [DW-1:0]        u_q;
    logic signed [SW-1:0] u_sq, u_sum, u_sat;
    logic signed [W-1:0]  u_new, u_nx, u_ny;
    always_comb begin
        if (r_dzero) begin
            u_q = r_pnz ? Q_LIMIT : '0;
        end else if (r_big || (r_quo > Q_LIMIT)) begin
            u_q = Q_LIMIT;
        end else begin
            u_q = r_quo;
        end
        u_sq  = r_neg ? -SW'(u_q) : SW'(u_q);
        u_sum = SW'(r_base) + u_sq;
        if (u_sum > SAT_HI) begin
            u_sat = SAT_HI;
        end else if (u_sum < SAT_LO) begin
            u_sat = SAT_LO;
        end else begin
            u_sat = u_sum;
        end
        u_new = u_sat[W-1:0];
        u_nx  = r_vert ? u_new : r_edge;
        u_ny  = r_vert ? r_edge : u_new;
    end

    always_comb begin
        n_x1 = r_x1;
        n_y1 = r_y1;
        n_x2 = r_x2;
        n_y2 = r_y2;
        if (i_cmd.load) begin
            n_x1 = i_start_x;
            n_y1 = i_start_y;
            n_x2 = i_end_x;
            n_y2 = i_end_y;
        end else if (i_cmd.update) begin
            if (r_sel1) begin
                n_x1 = u_nx;
                n_y1 = u_ny;
            end else begin
                n_x2 = u_nx;
                n_y2 = u_ny;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl <= RST_LEFT;
            r_wb <= RST_BOTTOM;
            r_wr <= RST_RIGHT;
            r_wt <= RST_TOP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lsc_pkg::CFG_WINDOW_LEFT:   r_wl <= i_cfg_data;
                lsc_pkg::CFG_WINDOW_BOTTOM: r_wb <= i_cfg_data;
                lsc_pkg::CFG_WINDOW_RIGHT:  r_wr <= i_cfg_data;
                lsc_pkg::CFG_WINDOW_TOP:    r_wt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1 <= n_x1;
        r_y1 <= n_y1;
        r_x2 <= n_x2;
        r_y2 <= n_y2;
        if (i_cmd.setup) begin
            r_ma    <= s_a[DW-1] ? -s_a : s_a;
            r_mb    <= s_b[DW-1] ? -s_b : s_b;
            r_md    <= s_d[DW-1] ? -s_d : s_d;
            r_dzero <= (s_d == '0);
            r_neg   <= (s_d == '0) ? (s_a[DW-1] ^ s_b[DW-1])
                                   : (s_a[DW-1] ^ s_b[DW-1] ^ s_d[DW-1]);
            r_vert  <= s_vert;
            r_edge  <= s_edge;
            r_base  <= s_base;
            r_sel1  <= (c1 != 4'd0);
        end
        if (i_cmd.mul) begin
            r_prod    <= PW'(r_ma * r_mb);
            r_rem     <= '0;
            r_quo     <= '0;
            r_big     <= 1'b0;
            r_cnt     <= CW'(PW - 1);
        end
        if (i_cmd.div_step) begin
            r_rem     <= d_ge ? (d_rem_sh - {1'b0, r_md}) : d_rem_sh;
            r_quo     <= {r_quo[DW-2:0], d_ge};
            r_big     <= r_big | r_quo[DW-1];
            r_prod_sh <= {r_prod_sh[PW-2:0], 1'b0};
            r_cnt     <= r_cnt - CW'(1);
        end else if (i_cmd.mul) begin
            r_prod_sh <= PW'(r_ma * r_mb);
        end
        r_pnz <= (r_prod != '0);
        if (i_cmd.out_load) begin
            o_accepted        <= i_cmd.out_acc;
            o_clipped_start_x <= r_x1;
            o_clipped_start_y <= r_y1;
            o_clipped_end_x   <= r_x2;
            o_clipped_end_y   <= r_y2;
        end
    end

endmodule
`default_nettype wire

// ----- sv/lsc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// sequencer for outcode test, multiply, divide and endpoint update
// depends on lsc_pkg
module lsc_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output lsc_pkg::t_cmd    o_cmd,
    input  lsc_pkg::t_status i_status
);
    lsc_pkg::t_state r_state, n_state;
    logic [lsc_pkg::STEP_W-1:0] r_steps, n_steps;
    logic r_acc, n_acc, r_out_valid, n_out_valid;
    logic w_slot;

    assign w_slot      = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != lsc_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            lsc_pkg::S_IDLE: if (i_in_valid) n_state = lsc_pkg::S_EVAL;
            lsc_pkg::S_EVAL: begin
                if (i_status.trivial_acc || i_status.trivial_rej ||
                    (r_steps == lsc_pkg::STEP_W'(lsc_pkg::MAX_CLIPS))) begin
                    n_state = lsc_pkg::S_DONE;
                end else begin
                    n_state = lsc_pkg::S_MUL;
                end
            end
            lsc_pkg::S_MUL: n_state = lsc_pkg::S_DIV;
            lsc_pkg::S_DIV: if (i_status.div_last) n_state = lsc_pkg::S_UPD;
            lsc_pkg::S_UPD: n_state = lsc_pkg::S_EVAL;
            lsc_pkg::S_DONE: if (w_slot) n_state = lsc_pkg::S_IDLE;
            default: n_state = lsc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        n_steps     = r_steps;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            lsc_pkg::S_IDLE: begin
                o_cmd.load = i_in_valid;
                n_steps    = '0;
            end
            lsc_pkg::S_EVAL: begin
                n_acc       = i_status.trivial_acc;
                o_cmd.setup = 1'b1;
            end
            lsc_pkg::S_MUL: o_cmd.mul = 1'b1;
            lsc_pkg::S_DIV: o_cmd.div_step = 1'b1;
            lsc_pkg::S_UPD: begin
                o_cmd.update = 1'b1;
                n_steps      = r_steps + lsc_pkg::STEP_W'(1);
            end
            lsc_pkg::S_DONE: begin
                o_cmd.out_load = w_slot;
                o_cmd.out_acc  = r_acc;
                if (w_slot) n_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsc_pkg::S_IDLE;
            r_steps     <= '0;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_steps     <= n_steps;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ----- sv/line_segment_clipper_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// line segment clipper against a window held in four registers
// Input channel: i_in_valid / o_in_stall, one beat carries both endpoints.
// Output channel: o_out_valid / i_out_stall, one beat per input beat with the
// accept flag and the endpoints as last updated.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0..3 selects
// window_left, window_bottom, window_right, window_top; other indexes ignored.
// Each clip step (at most four) runs a multiply, then a bit-serial divider
// retiring one quotient bit per cycle, then an endpoint update; an outcode
// test before each step decides a trivial accept or reject.
// One beat is processed at a time; the next beat is taken once the result
// has entered the output register.
// Reset: synchronous, window returns to 0,0..639,479, channels go empty.
// A stalled output holds its beat; the block finishes the next beat and
// waits before loading it.
// depends on lsc_pkg, lsc_ctrl, lsc_datapath
module line_segment_clipper_core #(
    parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire signed [COORD_WIDTH-1:0]      i_start_x,
    input  wire signed [COORD_WIDTH-1:0]      i_start_y,
    input  wire signed [COORD_WIDTH-1:0]      i_end_x,
    input  wire signed [COORD_WIDTH-1:0]      i_end_y,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic                              o_accepted,
    output logic signed [COORD_WIDTH-1:0]     o_clipped_start_x,
    output logic signed [COORD_WIDTH-1:0]     o_clipped_start_y,
    output logic signed [COORD_WIDTH-1:0]     o_clipped_end_x,
    output logic signed [COORD_WIDTH-1:0]     o_clipped_end_y,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [lsc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire signed [COORD_WIDTH-1:0]      i_cfg_data
);
    lsc_pkg::t_cmd    w_cmd;
    lsc_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    lsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    lsc_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_start_x         (i_start_x),
        .i_start_y         (i_start_y),
        .i_end_x           (i_end_x),
        .i_end_y           (i_end_y),
        .o_accepted        (o_accepted),
        .o_clipped_start_x (o_clipped_start_x),
        .o_clipped_start_y (o_clipped_start_y),
        .o_clipped_end_x   (o_clipped_end_x),
        .o_clipped_end_y   (o_clipped_end_y)
    );

endmodule
`default_nettype wire
